// ===== src/nkrt_pkg.sv =====
`default_nettype none
package nkrt_pkg;

	localparam int NAME_W = 64;
	localparam int ID_W   = 16;

	typedef enum logic [1:0] {
		OP_REGISTER = 2'd0,
		OP_LOOKUP   = 2'd1,
		OP_REMOVE   = 2'd2
	} op_t;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	// Request token that travels down the row of cells, one cell per cycle.
	typedef struct packed {
		logic              vld;
		op_t               op;
		logic [NAME_W-1:0] name;
		logic [ID_W-1:0]   id;
		logic              hit;
		logic              free;
		logic [ID_W-1:0]   found_id;
	} token_t;

	// Broadcast update applied by the one cell that the scan selected.
	typedef struct packed {
		logic              en;
		op_t               op;
		logic [NAME_W-1:0] name;
		logic [ID_W-1:0]   id;
	} commit_t;

endpackage
`default_nettype wire

// ===== src/nkrt_cell.sv =====
`default_nettype none
module nkrt_cell (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire nkrt_pkg::token_t  tok_in,
	output nkrt_pkg::token_t      tok_out,
	input  wire nkrt_pkg::commit_t commit
);
	import nkrt_pkg::*;

	logic              valid_q;
	logic [NAME_W-1:0] name_q;
	logic [ID_W-1:0]   owner_q;
	logic              sel_q;
	logic              tok_vld_q;
	token_t            tok_q;

	logic   match_name;
	logic   match_id;
	logic   sel_d;
	token_t tok_d;

	assign match_name = valid_q && (name_q == tok_in.name);
	assign match_id   = valid_q && (owner_q == tok_in.id);

	always_comb begin
		tok_d = tok_in;
		sel_d = 1'b0;
		case (tok_in.op)
			OP_REGISTER: begin
				// The first free cell claims the slot; a matching name anywhere vetoes it.
				sel_d      = !valid_q && !tok_in.free;
				tok_d.free = tok_in.free || !valid_q;
				tok_d.hit  = tok_in.hit || match_name;
			end
			OP_LOOKUP: begin
				if (match_name && !tok_in.hit) begin
					tok_d.hit      = 1'b1;
					tok_d.found_id = owner_q;
				end
			end
			OP_REMOVE: begin
				sel_d     = match_id && !tok_in.hit;
				tok_d.hit = tok_in.hit || match_id;
			end
			default: begin
				sel_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			sel_q     <= 1'b0;
			tok_vld_q <= 1'b0;
		end else begin
			tok_vld_q <= tok_in.vld;
			if (tok_in.vld) begin
				sel_q <= sel_d;
			end
			if (commit.en && sel_q) begin
				if (commit.op == OP_REGISTER) begin
					valid_q <= 1'b1;
				end else if (commit.op == OP_REMOVE) begin
					valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok_in.vld) begin
			tok_q <= tok_d;
		end
		if (commit.en && sel_q && (commit.op == OP_REGISTER)) begin
			name_q  <= commit.name;
			owner_q <= commit.id;
		end
	end

	always_comb begin
		tok_out     = tok_q;
		tok_out.vld = tok_vld_q;
	end

endmodule
`default_nettype wire

// ===== src/nkrt_ctrl.sv =====
`default_nettype none
module nkrt_ctrl #(
	parameter int NAME_BYTES = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [79:0]  s_axis_tdata,
	input  wire logic [1:0]   s_axis_tuser,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [15:0]       m_axis_tdata,
	output logic [1:0]        m_axis_tuser,
	output nkrt_pkg::token_t  tok_launch,
	input  wire nkrt_pkg::token_t tok_end,
	output nkrt_pkg::commit_t commit
);
	import nkrt_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	state_t            state_q;
	logic              launch_vld_q;
	token_t            launch_q;
	token_t            res_q;
	logic              out_vld_q;
	logic [1:0]        status_q;
	logic [ID_W-1:0]   found_q;

	logic [NAME_W-1:0] norm_name;
	logic              run;
	logic              accept;
	logic              release_res;
	logic [1:0]        status_d;
	logic [ID_W-1:0]   found_d;
	logic              commit_en;

	// A name is its leading nonzero bytes, up to NAME_BYTES of them.
	always_comb begin
		run       = 1'b1;
		norm_name = '0;
		for (int b = 0; b < 8; b++) begin
			if (b >= NAME_BYTES || s_axis_tdata[8*b +: 8] == 8'd0) begin
				run = 1'b0;
			end
			if (run) begin
				norm_name[8*b +: 8] = s_axis_tdata[8*b +: 8];
			end
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign release_res   = (state_q == S_DONE) && (!out_vld_q || m_axis_tready);

	always_comb begin
		status_d  = ST_MISS;
		found_d   = '0;
		commit_en = 1'b0;
		case (res_q.op)
			OP_REGISTER: begin
				if (res_q.hit) begin
					status_d = ST_MISS;
				end else if (res_q.free) begin
					status_d  = ST_OK;
					commit_en = 1'b1;
				end else begin
					status_d = ST_FULL;
				end
			end
			OP_LOOKUP: begin
				if (res_q.hit) begin
					status_d = ST_OK;
					found_d  = res_q.found_id;
				end
			end
			OP_REMOVE: begin
				if (res_q.hit) begin
					status_d  = ST_OK;
					commit_en = 1'b1;
				end
			end
			default: begin
				status_d = ST_MISS;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			launch_vld_q <= 1'b0;
			out_vld_q    <= 1'b0;
		end else begin
			launch_vld_q <= accept;
			out_vld_q    <= release_res || (out_vld_q && !m_axis_tready);
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (tok_end.vld) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (release_res) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			launch_q.vld      <= 1'b1;
			launch_q.op       <= op_t'(s_axis_tuser);
			launch_q.name     <= norm_name;
			launch_q.id       <= s_axis_tdata[79:64];
			launch_q.hit      <= 1'b0;
			launch_q.free     <= 1'b0;
			launch_q.found_id <= '0;
		end
		if (state_q == S_SCAN && tok_end.vld) begin
			res_q <= tok_end;
		end
		if (release_res) begin
			status_q <= status_d;
			found_q  <= found_d;
		end
	end

	always_comb begin
		tok_launch     = launch_q;
		tok_launch.vld = launch_vld_q;
	end

	always_comb begin
		commit.en   = release_res && commit_en;
		commit.op   = res_q.op;
		commit.name = res_q.name;
		commit.id   = res_q.id;
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = found_q;
	assign m_axis_tuser  = status_q;

endmodule
`default_nettype wire

// ===== src/name_keyed_registry_table.sv =====
// One operation is in flight at a time: a word is registered as the launch
// token, passes each cell's register in turn, is captured at the row's end,
// and only once its result is registered at the output is a new word taken.
// A finished result waits in the output register while the next word is taken.
// Reset clears every entry's valid mark, the control state and the output valid flag.
`default_nettype none
module name_keyed_registry_table #(
	parameter int TABLE_ENTRIES = 16,
	parameter int NAME_BYTES    = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [79:0] s_axis_tdata,  // key_name[63:0], owner_id[79:64]
	input  wire logic [1:0]  s_axis_tuser,  // op[1:0]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,  // found_id[15:0]
	output logic [1:0]       m_axis_tuser   // status[1:0]
);
	import nkrt_pkg::*;

	token_t  tok [TABLE_ENTRIES+1];
	commit_t commit;

	nkrt_ctrl #(
		.NAME_BYTES(NAME_BYTES)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.tok_launch   (tok[0]),
		.tok_end      (tok[TABLE_ENTRIES]),
		.commit       (commit)
	);

	// Entry 0 sits first in the row, so the first cell to claim is the lowest entry.
	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		nkrt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.tok_in (tok[i]),
			.tok_out(tok[i+1]),
			.commit (commit)
		);
	end

endmodule
`default_nettype wire

// ===== tb/name_keyed_registry_table_tb.sv =====
module name_keyed_registry_table_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import nkrt_pkg::*;

	localparam int ENTRIES    = 16;
	localparam int NAME_BYTES = 8;
	localparam int NAME_POOL  = 24;
	localparam int ID_POOL    = 8;
	localparam int ROUNDS     = 9;
	localparam int ROUND_LEN  = 97;
	localparam int HOLD_CYCLES = 250;
	localparam int IDLE_LIMIT = 4000;
	// The package has no member for the fourth op code; the block must ignore it.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct {
		logic [1:0]  status;
		logic [15:0] found_id;
	} reply_t;

	class registry_scoreboard;
		bit          entry_live[ENTRIES];
		bit [63:0]   entry_key[ENTRIES];
		bit [15:0]   entry_owner[ENTRIES];
		reply_t      expected_replies[$];
		int          errors;
		int          op_count[4];
		int          status_count[3];

		function bit [63:0] canonical_name(bit [63:0] raw);
			bit [63:0] cut;
			cut = '0;
			for (int b = 0; b < NAME_BYTES; b++) begin
				if (raw[8*b +: 8] == 8'd0)
					break;
				cut[8*b +: 8] = raw[8*b +: 8];
			end
			return cut;
		endfunction

		function int slot_of_name(bit [63:0] key);
			for (int i = 0; i < ENTRIES; i++)
				if (entry_live[i] && entry_key[i] == key)
					return i;
			return -1;
		endfunction

		function void note_request(logic [1:0] op, logic [63:0] raw_name, logic [15:0] id);
			reply_t    want;
			bit [63:0] key;
			int        slot;
			key = canonical_name(raw_name);
			want.status = ST_MISS;
			want.found_id = '0;
			op_count[op]++;
			case (op)
				OP_REGISTER: begin
					if (slot_of_name(key) < 0) begin
						want.status = ST_FULL;
						for (int i = 0; i < ENTRIES; i++) begin
							if (!entry_live[i]) begin
								entry_live[i] = 1'b1;
								entry_key[i] = key;
								entry_owner[i] = id;
								want.status = ST_OK;
								break;
							end
						end
					end
				end
				OP_LOOKUP: begin
					slot = slot_of_name(key);
					if (slot >= 0) begin
						want.status = ST_OK;
						want.found_id = entry_owner[slot];
					end
				end
				OP_REMOVE: begin
					for (int i = 0; i < ENTRIES; i++) begin
						if (entry_live[i] && entry_owner[i] == id) begin
							entry_live[i] = 1'b0;
							want.status = ST_OK;
							break;
						end
					end
				end
				default: ;
			endcase
			expected_replies.push_back(want);
		endfunction

		function void check_reply(logic [1:0] status, logic [15:0] found_id);
			reply_t want;
			if (expected_replies.size() == 0) begin
				$error("reply with nothing pending: status %0d found_id 0x%04h", status, found_id);
				errors++;
				return;
			end
			want = expected_replies.pop_front();
			status_count[want.status]++;
			if (status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, status);
				errors++;
			end
			if (found_id !== want.found_id) begin
				$error("found_id: expected 0x%04h, got 0x%04h", want.found_id, found_id);
				errors++;
			end
		endfunction

		function int pending();
			return expected_replies.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [79:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;

	registry_scoreboard sb = new();

	bit [63:0] name_pool[NAME_POOL];
	bit [15:0] id_pool[ID_POOL];
	bit        sender_steady;
	bit        receiver_steady;
	bit        hold_request;
	int        idle_cycles;

	name_keyed_registry_table #(
		.TABLE_ENTRIES(ENTRIES),
		.NAME_BYTES(NAME_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_gap(bit steady);
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 40)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Keeps the name but may fill the bytes past its terminating zero with junk,
	// which the block has to treat as absent.
	function automatic logic [63:0] name_variant(logic [63:0] base);
		int          len;
		logic [63:0] junk;
		len = 0;
		while (len < 8 && base[8*len +: 8] != 8'd0)
			len++;
		if (len >= 7 || $urandom_range(0, 1) == 0)
			return base;
		junk = {$urandom, $urandom};
		return base | (junk & ~((64'd1 << (8 * (len + 1))) - 64'd1));
	endfunction

	function automatic logic [63:0] pick_name();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return name_variant(name_pool[$urandom_range(0, NAME_POOL - 1)]);
		if (r < 95)
			return {$urandom, $urandom};
		return {$urandom, $urandom} & ~64'hFF;
	endfunction

	function automatic logic [15:0] pick_id();
		if ($urandom_range(0, 99) < 80)
			return id_pool[$urandom_range(0, ID_POOL - 1)];
		return $urandom_range(0, 65535);
	endfunction

	function automatic logic [1:0] pick_op(bit filling);
		int r;
		r = $urandom_range(0, 99);
		if (filling)
			return r < 55 ? OP_REGISTER : r < 75 ? OP_LOOKUP : r < 93 ? OP_REMOVE : OP_UNUSED;
		return r < 20 ? OP_REGISTER : r < 45 ? OP_LOOKUP : r < 93 ? OP_REMOVE : OP_UNUSED;
	endfunction

	task automatic send_word(logic [1:0] op, logic [63:0] key, logic [15:0] id);
		int gap;
		gap = pick_gap(sender_steady);
		if (gap > 0) begin
			@(negedge clk) s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {id, key};
		s_axis_tuser <= op;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_request(op, key, id);
	endtask

	// Receiver: random stalls, plus one long hold-off on request so the
	// output register fills and the input side backs up.
	initial begin
		int gap;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				@(negedge clk) m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end
			gap = pick_gap(receiver_steady);
			if (gap > 0) begin
				@(negedge clk) m_axis_tready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk) m_axis_tready <= 1'b1;
			do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_reply(m_axis_tuser, m_axis_tdata);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
				if (idle_cycles >= IDLE_LIMIT) begin
					$display("name_keyed_registry_table verification failed");
					$finish;
				end
			end
		end
	end

	initial begin
		logic [63:0] abc;
		int          len;
		abc = 64'h0000_0000_0063_6261;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = OP_REGISTER;
		sender_steady = 1'b0;
		receiver_steady = 1'b0;
		hold_request = 1'b0;
		idle_cycles = 0;
		for (int i = 0; i < NAME_POOL; i++) begin
			len = $urandom_range(1, 8);
			name_pool[i] = '0;
			for (int b = 0; b < len; b++)
				name_pool[i][8*b +: 8] = $urandom_range(1, 255);
		end
		id_pool[0] = 16'h0000;
		id_pool[1] = 16'hFFFF;
		for (int i = 2; i < ID_POOL; i++)
			id_pool[i] = $urandom_range(0, 65535);
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// Empty table: a lookup miss, a remove miss, and the unused op code.
		send_word(OP_LOOKUP, abc, 16'h0000);
		send_word(OP_REMOVE, 64'd0, 16'h1234);
		send_word(OP_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
		// Full-width name, the empty name, and a name with junk after its end.
		send_word(OP_REGISTER, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
		send_word(OP_REGISTER, 64'd0, 16'h0000);
		send_word(OP_REGISTER, 64'hA5A5_5A5A_0063_6261, 16'h0001);
		send_word(OP_REGISTER, abc, 16'h0003);
		send_word(OP_LOOKUP, 64'h1234_5678_0063_6261, 16'hFFFF);
		send_word(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0000);
		send_word(OP_LOOKUP, 64'hDEAD_BEEF_CAFE_0000, 16'h5555);
		for (int i = 0; i < ENTRIES - 3; i++)
			send_word(OP_REGISTER, {48'd0, 8'h30 + 8'(i), 8'h6E}, 16'h0100 + 16'(i));
		send_word(OP_REGISTER, {48'd0, 8'h30 + 8'(ENTRIES), 8'h6E}, 16'h0200);
		send_word(OP_UNUSED, abc, 16'h0001);
		// Freeing the entry that holds the short name lets it be taken again.
		send_word(OP_REMOVE, 64'hFFFF_0000_FFFF_0000, 16'h0001);
		send_word(OP_REGISTER, abc, 16'h0002);
		send_word(OP_LOOKUP, abc, 16'h0000);

		// Alternate draining and filling so both the empty and the full
		// table keep coming back.
		for (int r = 0; r < ROUNDS; r++) begin
			sender_steady = (r % 3 == 2);
			receiver_steady = (r % 4 == 1);
			if (r == 3)
				hold_request = 1'b1;
			for (int k = 0; k < ROUND_LEN; k++)
				send_word(pick_op(r % 2 == 1), pick_name(), pick_id());
		end
		@(negedge clk) s_axis_tvalid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (ENTRIES + 8) @(posedge clk);

		$display("Sent %0d registers, %0d lookups, %0d removes and %0d unused-op words.",
			sb.op_count[OP_REGISTER], sb.op_count[OP_LOOKUP], sb.op_count[OP_REMOVE],
			sb.op_count[OP_UNUSED]);
		$display("Replies checked: %0d done or found, %0d duplicate or miss, %0d table full.",
			sb.status_count[ST_OK], sb.status_count[ST_MISS], sb.status_count[ST_FULL]);
		if (sb.errors == 0)
			$display("name_keyed_registry_table verification clean");
		else
			$display("name_keyed_registry_table verification failed");
		$finish;
	end

endmodule
